// ===== rtl/pat_pkg.sv =====
`default_nettype none

package pat_pkg;

    // Field widths of the transfer payloads
    localparam int ADDR_W       = 16;
    localparam int PAGE_OUT_W   = 3;
    localparam int OFFSET_OUT_W = 13;
    localparam int FRAME_OUT_W  = 11;
    localparam int PHYS_W       = 24;
    localparam int TOTAL_W      = 32;

    // Configuration register widths and indexes
    localparam int CFG_IDX_W  = 2;
    localparam int FCNT_W     = 4;
    localparam int START_W    = 11;
    localparam int CFG_DATA_W = 11;

    localparam logic [CFG_IDX_W-1:0] CFG_POLICY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAMES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START  = 2'd2;

    // Codes
    localparam logic POLICY_FIFO  = 1'b0;
    localparam logic POLICY_CLOCK = 1'b1;
    localparam logic ACT_READ     = 1'b0;
    localparam logic ACT_WRITE    = 1'b1;

    localparam logic [FCNT_W-1:0] FCNT_RESET = 4'd8;

    // Defaults for the top level parameters
    localparam int PAGES_DEF       = 8;
    localparam int OFFSET_BITS_DEF = 13;
    localparam int FRAME_BITS_DEF  = 11;

    typedef struct packed {
        logic [ADDR_W-1:0] address;
        logic              action;
    } pat_in_t;

    typedef struct packed {
        logic [PAGE_OUT_W-1:0]   page;
        logic [OFFSET_OUT_W-1:0] offset;
        logic [FRAME_OUT_W-1:0]  frame;
        logic [PHYS_W-1:0]       physical_address;
        logic                    fault;
        logic                    write_back;
        logic [TOTAL_W-1:0]      fault_total;
        logic [TOTAL_W-1:0]      writeback_total;
    } pat_out_t;

endpackage

`default_nettype wire

// ===== rtl/paged_address_translator.sv =====
// Sequence: S_IDLE takes a transfer and reads the page table; S_LOOK serves a hit or a
// fault from a free frame and goes to S_OUT. An eviction runs S_VPT and S_VCHK once more
// for each referenced bit the clock hand clears (none under FIFO, at most 2 * resident
// pages under clock); each hand step waits on the registered page-table and ring reads.
// A new transfer is taken only in S_IDLE, after S_OUT registers the last result; S_OUT waits while the output stalls.
// Reset: asynchronous, clears page valid bits, counters and hand, and sets the configuration to its defaults at once.
`default_nettype none

module paged_address_translator
    import pat_pkg::*;
#(
    parameter int PAGES       = PAGES_DEF,
    parameter int OFFSET_BITS = OFFSET_BITS_DEF,
    parameter int FRAME_BITS  = FRAME_BITS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire pat_in_t               in_data,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output pat_out_t                   out_data,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int PG_W   = $clog2(PAGES);
    localparam int CNT_W  = $clog2(PAGES + 1);
    localparam int STEP_W = CNT_W + 1;
    localparam int PTE_W  = FRAME_BITS + 2;
    localparam int CMP_W  = (CNT_W > FCNT_W) ? CNT_W : FCNT_W;
    localparam int SUM_W  = ((FRAME_BITS > START_W) ? FRAME_BITS : START_W) + 1;
    localparam int PA_W   = FRAME_BITS + OFFSET_BITS;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LOOK = 3'd1;
    localparam logic [2:0] S_VPT  = 3'd2;
    localparam logic [2:0] S_VCHK = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    // Control and state registers
    logic [2:0]             state_reg, state_next;
    logic [PG_W-1:0]        page_reg, page_next;
    logic [OFFSET_BITS-1:0] offset_reg, offset_next;
    logic                   write_reg, write_next;
    logic [PG_W-1:0]        hand_reg, hand_next;
    logic [STEP_W-1:0]      steps_reg, steps_next;
    logic [PG_W-1:0]        vpg_reg, vpg_next;
    logic [FRAME_BITS-1:0]  frame_res_reg, frame_res_next;
    logic                   fault_res_reg, fault_res_next;
    logic                   wb_res_reg, wb_res_next;
    logic [CNT_W-1:0]       fiu_reg, fiu_next;
    logic [PG_W-1:0]        ring_hand_reg, ring_hand_next;
    logic [TOTAL_W-1:0]     fault_cnt_reg, fault_cnt_next;
    logic [TOTAL_W-1:0]     wb_cnt_reg, wb_cnt_next;
    logic [PAGES-1:0]       valid_reg, valid_next;
    logic                   out_valid_reg, out_valid_next;
    pat_out_t               out_data_reg, out_data_next;

    logic                   policy_reg;
    logic [FCNT_W-1:0]      frame_count_reg;
    logic [START_W-1:0]     start_frame_reg;

    // Memory ports
    logic [PTE_W-1:0]       pt_mem [PAGES];
    logic                   pt_rd_en;
    logic [PG_W-1:0]        pt_rd_addr;
    logic [PTE_W-1:0]       pt_rdata_reg;
    logic                   pt_we;
    logic [PG_W-1:0]        pt_wa;
    logic [PTE_W-1:0]       pt_wd;

    logic [PG_W-1:0]        ring_mem [PAGES];
    logic                   ring_rd_en;
    logic [PG_W-1:0]        ring_rd_addr;
    logic [PG_W-1:0]        ring_rdata_reg;
    logic                   ring_we;
    logic [PG_W-1:0]        ring_wa;
    logic [PG_W-1:0]        ring_wd;

    // Helpers
    logic [PG_W-1:0]        split_page;
    logic [OFFSET_BITS-1:0] split_offset;
    logic                   rd_ref;
    logic                   rd_mod;
    logic [FRAME_BITS-1:0]  rd_frame;
    logic [CMP_W-1:0]       fc_ext;
    logic [CNT_W-1:0]       allowed;
    logic [SUM_W-1:0]       frame_sum;
    logic [FRAME_BITS-1:0]  new_frame;
    logic [CNT_W-1:0]       hand_plus;
    logic [PG_W-1:0]        hand_inc;
    logic                   victim_wb;
    logic [PA_W-1:0]        pa_full;

    pat_addr_split #(
        .PAGES       (PAGES),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_split (
        .address (in_data.address),
        .page    (split_page),
        .offset  (split_offset)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign cfg_ready = 1'b1;

    assign rd_ref   = pt_rdata_reg[PTE_W-1];
    assign rd_mod   = pt_rdata_reg[PTE_W-2];
    assign rd_frame = pt_rdata_reg[FRAME_BITS-1:0];

    // Frame allowance, saturated into one to the page count
    always_comb
    begin
        fc_ext = CMP_W'(frame_count_reg);
        if (fc_ext == '0)
        begin
            allowed = CNT_W'(1);
        end
        else if (fc_ext > CMP_W'(PAGES))
        begin
            allowed = CNT_W'(PAGES);
        end
        else
        begin
            allowed = CNT_W'(fc_ext);
        end
    end

    assign frame_sum = SUM_W'(start_frame_reg) + SUM_W'(fiu_reg);
    assign new_frame = frame_sum[FRAME_BITS-1:0];

    // Hand advance around the resident ring
    assign hand_plus = CNT_W'(hand_reg) + CNT_W'(1);
    assign hand_inc  = (hand_plus == fiu_reg) ? '0 : hand_plus[PG_W-1:0];

    assign victim_wb = valid_reg[vpg_reg] & rd_mod;
    assign pa_full   = {frame_res_reg, offset_reg};

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        page_next      = page_reg;
        offset_next    = offset_reg;
        write_next     = write_reg;
        hand_next      = hand_reg;
        steps_next     = steps_reg;
        vpg_next       = vpg_reg;
        frame_res_next = frame_res_reg;
        fault_res_next = fault_res_reg;
        wb_res_next    = wb_res_reg;
        fiu_next       = fiu_reg;
        ring_hand_next = ring_hand_reg;
        fault_cnt_next = fault_cnt_reg;
        wb_cnt_next    = wb_cnt_reg;
        valid_next     = valid_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg & ~out_ready;

        pt_rd_en     = 1'b0;
        pt_rd_addr   = page_reg;
        pt_we        = 1'b0;
        pt_wa        = page_reg;
        pt_wd        = {1'b1, write_reg, rd_frame};
        ring_rd_en   = 1'b0;
        ring_rd_addr = ring_hand_reg;
        ring_we      = 1'b0;
        ring_wa      = hand_reg;
        ring_wd      = page_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    page_next   = split_page;
                    offset_next = split_offset;
                    write_next  = (in_data.action == ACT_WRITE);
                    pt_rd_en    = 1'b1;
                    pt_rd_addr  = split_page;
                    state_next  = S_LOOK;
                end
            end

            S_LOOK:
            begin
                // ring slot under the hand is fetched in case of eviction
                ring_rd_en   = 1'b1;
                ring_rd_addr = ring_hand_reg;
                if (valid_reg[page_reg])
                begin
                    pt_we          = 1'b1;
                    pt_wd          = {1'b1, rd_mod | write_reg, rd_frame};
                    frame_res_next = rd_frame;
                    fault_res_next = 1'b0;
                    wb_res_next    = 1'b0;
                    state_next     = S_OUT;
                end
                else if (fiu_reg < allowed)
                begin
                    // free frame handed out, page appended to the ring
                    pt_we                = 1'b1;
                    pt_wd                = {1'b1, write_reg, new_frame};
                    ring_we              = 1'b1;
                    ring_wa              = fiu_reg[PG_W-1:0];
                    fiu_next             = fiu_reg + CNT_W'(1);
                    valid_next[page_reg] = 1'b1;
                    fault_cnt_next       = fault_cnt_reg + TOTAL_W'(1);
                    frame_res_next       = new_frame;
                    fault_res_next       = 1'b1;
                    wb_res_next          = 1'b0;
                    state_next           = S_OUT;
                end
                else
                begin
                    hand_next  = ring_hand_reg;
                    steps_next = '0;
                    state_next = S_VPT;
                end
            end

            S_VPT:
            begin
                pt_rd_en   = 1'b1;
                pt_rd_addr = ring_rdata_reg;
                vpg_next   = ring_rdata_reg;
                state_next = S_VCHK;
            end

            S_VCHK:
            begin
                if ((policy_reg == POLICY_CLOCK) && (steps_reg < {fiu_reg, 1'b0}) && rd_ref)
                begin
                    // second chance: clear referenced bit, move on
                    pt_we        = 1'b1;
                    pt_wa        = vpg_reg;
                    pt_wd        = {1'b0, rd_mod, rd_frame};
                    hand_next    = hand_inc;
                    steps_next   = steps_reg + STEP_W'(1);
                    ring_rd_en   = 1'b1;
                    ring_rd_addr = hand_inc;
                    state_next   = S_VPT;
                end
                else
                begin
                    // evict the page under the hand, its frame goes to the new page
                    valid_next[vpg_reg]  = 1'b0;
                    valid_next[page_reg] = 1'b1;
                    pt_we                = 1'b1;
                    pt_wd                = {1'b1, write_reg, rd_frame};
                    ring_we              = 1'b1;
                    ring_wa              = hand_reg;
                    ring_hand_next       = hand_inc;
                    fault_cnt_next       = fault_cnt_reg + TOTAL_W'(1);
                    wb_cnt_next          = wb_cnt_reg + TOTAL_W'(victim_wb);
                    frame_res_next       = rd_frame;
                    fault_res_next       = 1'b1;
                    wb_res_next          = victim_wb;
                    state_next           = S_OUT;
                end
            end

            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_data_next.page             = PAGE_OUT_W'(page_reg);
                    out_data_next.offset           = OFFSET_OUT_W'(offset_reg);
                    out_data_next.frame            = FRAME_OUT_W'(frame_res_reg);
                    out_data_next.physical_address = PHYS_W'(pa_full);
                    out_data_next.fault            = fault_res_reg;
                    out_data_next.write_back       = wb_res_reg;
                    out_data_next.fault_total      = fault_cnt_reg;
                    out_data_next.writeback_total  = wb_cnt_reg;
                    out_valid_next                 = 1'b1;
                    state_next                     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fiu_reg       <= '0;
            ring_hand_reg <= '0;
            fault_cnt_reg <= '0;
            wb_cnt_reg    <= '0;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fiu_reg       <= fiu_next;
            ring_hand_reg <= ring_hand_next;
            fault_cnt_reg <= fault_cnt_next;
            wb_cnt_reg    <= wb_cnt_next;
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg      <= POLICY_FIFO;
            frame_count_reg <= FCNT_RESET;
            start_frame_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_POLICY: policy_reg      <= cfg_data[0];
                CFG_FRAMES: frame_count_reg <= cfg_data[FCNT_W-1:0];
                CFG_START:  start_frame_reg <= cfg_data[START_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        page_reg      <= page_next;
        offset_reg    <= offset_next;
        write_reg     <= write_next;
        hand_reg      <= hand_next;
        steps_reg     <= steps_next;
        vpg_reg       <= vpg_next;
        frame_res_reg <= frame_res_next;
        fault_res_reg <= fault_res_next;
        wb_res_reg    <= wb_res_next;
        out_data_reg  <= out_data_next;
    end

    // Page table memory: referenced, modified, frame
    always_ff @(posedge clk)
    begin
        if (pt_we)
        begin
            pt_mem[pt_wa] <= pt_wd;
        end
        if (pt_rd_en)
        begin
            pt_rdata_reg <= pt_mem[pt_rd_addr];
        end
    end

    // Resident ring memory
    always_ff @(posedge clk)
    begin
        if (ring_we)
        begin
            ring_mem[ring_wa] <= ring_wd;
        end
        if (ring_rd_en)
        begin
            ring_rdata_reg <= ring_mem[ring_rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/pat_addr_split.sv =====
`default_nettype none

module pat_addr_split
    import pat_pkg::*;
#(
    parameter int PAGES       = PAGES_DEF,
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
)
(
    input  wire logic [ADDR_W-1:0]          address,
    output logic      [$clog2(PAGES)-1:0]   page,
    output logic      [OFFSET_BITS-1:0]     offset
);

    localparam int PG_W  = $clog2(PAGES);
    localparam int HI_W  = ADDR_W - OFFSET_BITS;
    localparam int IDX_W = (HI_W > 0) ? HI_W : 1;
    localparam int TBL_N = 1 << IDX_W;

    logic [ADDR_W-1:0] shifted;
    logic [IDX_W-1:0]  hi;
    logic [PG_W-1:0]   page_lut [TBL_N];

    // Page number table: upper address bits folded modulo the page count
    genvar i;
    for (i = 0; i < TBL_N; i++)
    begin : g_lut
        localparam int unsigned PG = i % PAGES;
        assign page_lut[i] = PG_W'(PG);
    end

    assign shifted = address >> OFFSET_BITS;
    assign hi      = shifted[IDX_W-1:0];
    assign page    = page_lut[hi];
    assign offset  = address[OFFSET_BITS-1:0];

endmodule

`default_nettype wire
